// File: hdl/kbsa_pkg.sv
// Shared constants, result type and set 2 translation table for the scancode assembler.
// No dependencies; used by kbsa_decode and keyboard_scancode_assembler_core.
package kbsa_pkg;

   localparam logic [7:0] PFX_PAUSE      = 8'hE1;
   localparam logic [7:0] PFX_EXT        = 8'hE0;
   localparam logic [7:0] PFX_BREAK      = 8'hF0;
   localparam logic [7:0] S1_PRTSC_MAKE  = 8'h2A;
   localparam logic [7:0] S1_PRTSC_BREAK = 8'hB7;
   localparam logic [7:0] KEY_PAUSE      = 8'd119;
   localparam logic [7:0] KEY_PRTSC      = 8'd99;
   localparam logic [7:0] S1_BREAK_BASE  = 8'd128;

   localparam logic SET_ONE = 1'b0;
   localparam logic SET_TWO = 1'b1;

   localparam int ROM_DEPTH = 132;
   localparam logic [7:0] ROM_LAST = 8'd131;

   typedef struct packed {
      logic       done;
      logic [7:0] key_code;
      logic       released;
      logic [2:0] next_count;
   } kbsa_result_type;

   localparam logic [7:0] SET2_ROM [ROM_DEPTH] = '{
      8'd0,  8'd67, 8'd0,  8'd63, 8'd61, 8'd59, 8'd60, 8'd88,
      8'd0,  8'd68, 8'd66, 8'd64, 8'd62, 8'd15, 8'd41, 8'd0,
      8'd0,  8'd56, 8'd42, 8'd0,  8'd29, 8'd16, 8'd2,  8'd0,
      8'd0,  8'd0,  8'd44, 8'd31, 8'd30, 8'd17, 8'd3,  8'd0,
      8'd0,  8'd46, 8'd45, 8'd32, 8'd18, 8'd5,  8'd4,  8'd0,
      8'd0,  8'd57, 8'd47, 8'd33, 8'd20, 8'd19, 8'd6,  8'd0,
      8'd0,  8'd49, 8'd48, 8'd35, 8'd34, 8'd21, 8'd7,  8'd0,
      8'd0,  8'd0,  8'd50, 8'd36, 8'd22, 8'd8,  8'd9,  8'd0,
      8'd0,  8'd51, 8'd37, 8'd23, 8'd24, 8'd11, 8'd10, 8'd0,
      8'd0,  8'd52, 8'd53, 8'd38, 8'd39, 8'd25, 8'd12, 8'd0,
      8'd0,  8'd0,  8'd40, 8'd0,  8'd26, 8'd13, 8'd0,  8'd0,
      8'd58, 8'd54, 8'd28, 8'd27, 8'd0,  8'd43, 8'd0,  8'd0,
      8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd14, 8'd0,
      8'd0,  8'd79, 8'd0,  8'd75, 8'd71, 8'd0,  8'd0,  8'd0,
      8'd82, 8'd83, 8'd80, 8'd76, 8'd77, 8'd72, 8'd1,  8'd69,
      8'd87, 8'd78, 8'd81, 8'd74, 8'd55, 8'd73, 8'd70, 8'd0,
      8'd0,  8'd0,  8'd0,  8'd65
   };

   function automatic logic [7:0] set2_lookup(input logic [7:0] code);
      logic [7:0] key;
      key = 8'd0;
      if (code <= ROM_LAST) begin
         key = SET2_ROM[code];
      end
      return key;
   endfunction

endpackage

// File: hdl/kbsa_decode.sv
// Combinational decode of one scancode byte against the partial sequence.
// Depends on kbsa_pkg for prefix constants, the set 2 table and the result type.
module kbsa_decode (
   input  logic                      scan_set,
   input  logic [2:0]                byte_count,
   input  logic [7:0]                first_byte,
   input  logic [7:0]                second_byte,
   input  logic [7:0]                scan_byte,
   output logic [7:0]                first_out,
   output logic [7:0]                second_out,
   output kbsa_pkg::kbsa_result_type result
);

   logic [3:0] n;
   logic [7:0] b0;
   logic [7:0] b1;
   logic       done;
   logic [7:0] key;
   logic       rel;

   assign n  = {1'b0, byte_count} + 4'd1;
   assign b0 = (byte_count == 3'd0) ? scan_byte : first_byte;
   assign b1 = (byte_count == 3'd1) ? scan_byte : second_byte;
   assign first_out  = b0;
   assign second_out = b1;

   always_comb begin
      done = 1'b0;
      key  = 8'd0;
      rel  = 1'b0;
      if (scan_set == kbsa_pkg::SET_ONE) begin
         if (b0 == kbsa_pkg::PFX_PAUSE) begin
            done = (n == 4'd6);
            key  = kbsa_pkg::KEY_PAUSE;
         end else if (b0 == kbsa_pkg::PFX_EXT) begin
            if (b1 == kbsa_pkg::S1_PRTSC_MAKE || b1 == kbsa_pkg::S1_PRTSC_BREAK) begin
               done = (n == 4'd4);
               key  = kbsa_pkg::KEY_PRTSC;
               rel  = (b1 == kbsa_pkg::S1_PRTSC_BREAK);
            end else begin
               done = (n == 4'd2);
            end
         end else begin
            done = (n == 4'd1);
            if (b0 > kbsa_pkg::S1_BREAK_BASE) begin
               // break code: strip the top bit
               key = {1'b0, b0[6:0]};
               rel = 1'b1;
            end else begin
               key = b0;
            end
         end
      end else begin
         if (b0 == kbsa_pkg::PFX_PAUSE) begin
            done = (n == 4'd8);
         end else if (b0 == kbsa_pkg::PFX_EXT) begin
            if (b1 == kbsa_pkg::PFX_BREAK) begin
               done = (n == 4'd3);
               rel  = 1'b1;
            end else begin
               done = (n == 4'd2);
            end
         end else if (b0 == kbsa_pkg::PFX_BREAK) begin
            done = (n == 4'd2);
            key  = kbsa_pkg::set2_lookup(b1);
            rel  = 1'b1;
         end else begin
            done = (n == 4'd1);
            key  = kbsa_pkg::set2_lookup(b0);
         end
      end
   end

   assign result.done       = done;
   assign result.key_code   = done ? key : 8'd0;
   assign result.released   = done & rel;
   assign result.next_count = done ? 3'd0 : n[2:0];

endmodule

// File: hdl/keyboard_scancode_assembler_core.sv
// Top level of the keyboard scancode assembler: input word register, decode, result register.
// Depends on kbsa_pkg and kbsa_decode.
//
// Usage:
//   req_*  : one raw keyboard scancode byte per word (tdata[7:0] = scan_byte).
//   rsp_*  : one word per completed sequence, tdata[7:0] = key_code, tuser[0] = released.
//            Bytes that only extend a sequence (prefixes, pause tail bytes) give no word.
//   csr_*  : write of scan_set (0 = set 1 rules, 1 = set 2 rules). A write also drops
//            any partial sequence. Write only while the block is idle.
// Timing:
//   A byte taken into the input register is decoded against the held sequence state and,
//   once the result slot is free, its result word is registered and shown from then on.
//   One byte per cycle is sustained while the result slot is free; the decode pass is a
//   single level of compare and table logic between the two registers.
// Reset:
//   Synchronous, active high. Clears scan_set, sequence state and both valid flags.
// Stall:
//   While rsp_tvalid is high and rsp_tready low the result word holds; a byte already in
//   the input register waits there, and req_tready drops once that register is full.
module keyboard_scancode_assembler_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] scan_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] key_code
   output logic [0:0] rsp_tuser,   // [0] released
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [0:0] csr_data     // [0] scan_set
);

   // input word register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;

   // sequence state
   logic       scan_set_ff,    scan_set_in;
   logic [7:0] first_byte_ff,  first_byte_in;
   logic [7:0] second_byte_ff, second_byte_in;
   logic [2:0] byte_count_ff,  byte_count_in;

   // result word register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_key_ff,   rsp_key_in;
   logic       rsp_rel_ff,   rsp_rel_in;

   logic       out_free;
   logic       step;
   logic       req_take;
   logic       csr_take;
   logic [7:0] first_dec;
   logic [7:0] second_dec;
   kbsa_pkg::kbsa_result_type dec;

   kbsa_decode u_decode (
      .scan_set    (scan_set_ff),
      .byte_count  (byte_count_ff),
      .first_byte  (first_byte_ff),
      .second_byte (second_byte_ff),
      .scan_byte   (in_byte_ff),
      .first_out   (first_dec),
      .second_out  (second_dec),
      .result      (dec)
   );

   // the result slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_take   = csr_valid;

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_byte_in     = in_byte_ff;
      scan_set_in    = scan_set_ff;
      first_byte_in  = first_byte_ff;
      second_byte_in = second_byte_ff;
      byte_count_in  = byte_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_rel_in     = rsp_rel_ff;

      // drop the shown word once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // advance the held byte through decode
      if (step) begin
         in_valid_in    = 1'b0;
         first_byte_in  = first_dec;
         second_byte_in = second_dec;
         byte_count_in  = dec.next_count;
         if (dec.done) begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = dec.key_code;
            rsp_rel_in   = dec.released;
         end
      end

      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end

      // a mode change abandons any partial sequence
      if (csr_take) begin
         scan_set_in   = csr_data[0];
         byte_count_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         scan_set_ff    <= kbsa_pkg::SET_ONE;
         first_byte_ff  <= 8'd0;
         second_byte_ff <= 8'd0;
         byte_count_ff  <= 3'd0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         scan_set_ff    <= scan_set_in;
         first_byte_ff  <= first_byte_in;
         second_byte_ff <= second_byte_in;
         byte_count_ff  <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_key_ff <= rsp_key_in;
      rsp_rel_ff <= rsp_rel_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_key_ff;
   assign rsp_tuser[0] = rsp_rel_ff;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for keyboard_scancode_assembler_core: scancode bytes in, key events out.
// Needs kbsa_pkg for the set codes; the expected events come from an independent predictor.
module tb_top;

   // Prefix bytes and fixed key numbers of the two scancode sets
   localparam logic [7:0] BYTE_PAUSE        = 8'hE1;
   localparam logic [7:0] BYTE_EXT          = 8'hE0;
   localparam logic [7:0] BYTE_BREAK        = 8'hF0;
   localparam logic [7:0] PRTSC_MAKE        = 8'h2A;
   localparam logic [7:0] PRTSC_BREAK       = 8'hB7;
   localparam logic [7:0] CODE_PAUSE        = 8'd119;
   localparam logic [7:0] CODE_PRTSC        = 8'd99;
   localparam logic [7:0] SET1_RELEASE_BASE = 8'd128;

   localparam int KEY_MAP_DEPTH  = 132;
   localparam int DRAIN_CYCLES   = 6;     // margin for the result pipe to drain
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 80;
   localparam int PHASE_BYTES    = 500;

   // Set 2 make-code to key number; codes past the end map to 0
   localparam logic [7:0] KEY_MAP [KEY_MAP_DEPTH] = '{
      8'd0,  8'd67, 8'd0,  8'd63, 8'd61, 8'd59, 8'd60, 8'd88,
      8'd0,  8'd68, 8'd66, 8'd64, 8'd62, 8'd15, 8'd41, 8'd0,
      8'd0,  8'd56, 8'd42, 8'd0,  8'd29, 8'd16, 8'd2,  8'd0,
      8'd0,  8'd0,  8'd44, 8'd31, 8'd30, 8'd17, 8'd3,  8'd0,
      8'd0,  8'd46, 8'd45, 8'd32, 8'd18, 8'd5,  8'd4,  8'd0,
      8'd0,  8'd57, 8'd47, 8'd33, 8'd20, 8'd19, 8'd6,  8'd0,
      8'd0,  8'd49, 8'd48, 8'd35, 8'd34, 8'd21, 8'd7,  8'd0,
      8'd0,  8'd0,  8'd50, 8'd36, 8'd22, 8'd8,  8'd9,  8'd0,
      8'd0,  8'd51, 8'd37, 8'd23, 8'd24, 8'd11, 8'd10, 8'd0,
      8'd0,  8'd52, 8'd53, 8'd38, 8'd39, 8'd25, 8'd12, 8'd0,
      8'd0,  8'd0,  8'd40, 8'd0,  8'd26, 8'd13, 8'd0,  8'd0,
      8'd58, 8'd54, 8'd28, 8'd27, 8'd0,  8'd43, 8'd0,  8'd0,
      8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd14, 8'd0,
      8'd0,  8'd79, 8'd0,  8'd75, 8'd71, 8'd0,  8'd0,  8'd0,
      8'd82, 8'd83, 8'd80, 8'd76, 8'd77, 8'd72, 8'd1,  8'd69,
      8'd87, 8'd78, 8'd81, 8'd74, 8'd55, 8'd73, 8'd70, 8'd0,
      8'd0,  8'd0,  8'd0,  8'd65
   };

   typedef struct packed {
      logic [7:0] key_code;
      logic       released;
   } key_event_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;    // [7:0] scan_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] key_code
   logic [0:0] rsp_tuser;           // [0] released
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [0:0] csr_data = 1'b0;     // [0] scan_set

   keyboard_scancode_assembler_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Stimulus and expectations
   logic [7:0]    scan_bytes [$];
   key_event_type expected_keys [$];

   // Predictor copy of the block's sequence state
   logic         cur_set = kbsa_pkg::SET_ONE;
   logic [7:0]   seq_first = 8'd0;
   logic [7:0]   seq_second = 8'd0;
   logic [2:0]   seq_len = 3'd0;

   int unsigned  fail_count = 0;
   int unsigned  gap_left = 0;
   int unsigned  stall_left = 0;
   int unsigned  long_hold_left = 0;
   int unsigned  idle_cycles = 0;
   bit           long_hold_req = 1'b0;
   bit           quiet = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] set2_key(input logic [7:0] code);
      logic [7:0] key;
      key = 8'd0;
      if (code < KEY_MAP_DEPTH) begin
         key = KEY_MAP[code];
      end
      return key;
   endfunction

   // Advance the sequence state by one byte; queue a key event when a sequence completes
   task automatic assemble_scancode(input logic [7:0] b);
      int            n;
      logic          done;
      key_event_type ev;
      n = seq_len + 1;
      done = 1'b0;
      ev = '0;
      if (n == 1) begin
         seq_first = b;
      end else if (n == 2) begin
         seq_second = b;
      end
      if (cur_set == kbsa_pkg::SET_ONE) begin
         if (seq_first == BYTE_PAUSE) begin
            done = (n == 6);
            ev.key_code = CODE_PAUSE;
         end else if (seq_first == BYTE_EXT) begin
            // print screen make and break run to four bytes, other extended keys to two
            if (n >= 2) begin
               if (seq_second == PRTSC_MAKE || seq_second == PRTSC_BREAK) begin
                  done = (n == 4);
                  ev.key_code = CODE_PRTSC;
                  ev.released = (seq_second == PRTSC_BREAK);
               end else begin
                  done = (n == 2);
               end
            end
         end else begin
            // 0x80 itself is not above the base, so it is a press of key 128
            done = (n == 1);
            if (seq_first > SET1_RELEASE_BASE) begin
               ev.key_code = seq_first - SET1_RELEASE_BASE;
               ev.released = 1'b1;
            end else begin
               ev.key_code = seq_first;
            end
         end
      end else begin
         if (seq_first == BYTE_PAUSE) begin
            done = (n == 8);
         end else if (seq_first == BYTE_EXT) begin
            if (n >= 2) begin
               if (seq_second == BYTE_BREAK) begin
                  done = (n == 3);
                  ev.released = 1'b1;
               end else begin
                  done = (n == 2);
               end
            end
         end else if (seq_first == BYTE_BREAK) begin
            done = (n == 2);
            ev.key_code = set2_key(seq_second);
            ev.released = 1'b1;
         end else begin
            done = (n == 1);
            ev.key_code = set2_key(seq_first);
         end
      end
      if (done) begin
         expected_keys.push_back(ev);
         seq_len = 3'd0;
      end else begin
         seq_len = n[2:0];
      end
   endtask

   // Driver: hold the word until taken, then advance to the next pending byte or idle
   always @(posedge clock) begin : drive_scan_bytes
      logic       nxt_valid;
      logic [7:0] nxt_data;
      nxt_valid = req_tvalid;
      nxt_data = req_tdata;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            assemble_scancode(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (scan_bytes.size() != 0) begin
               if (!quiet && $urandom_range(0, 7) == 0) begin
                  gap_left = $urandom_range(0, 3);
               end else begin
                  nxt_valid = 1'b1;
                  nxt_data = scan_bytes.pop_front();
               end
            end
         end
      end
      req_tvalid <= nxt_valid;
      req_tdata <= nxt_data;
   end

   // Monitor: check each taken result word against the oldest expected key event
   always @(posedge clock) begin : check_key_events
      key_event_type got;
      key_event_type want;
      logic          nxt_ready;
      if (rsp_tvalid && rsp_tready) begin
         got.key_code = rsp_tdata;
         got.released = rsp_tuser[0];
         if (expected_keys.size() == 0) begin
            fail_count++;
            $display("%0t: expected no key event, got key_code=%0d released=%0d",
                     $time, got.key_code, got.released);
         end else begin
            want = expected_keys.pop_front();
            if (got !== want) begin
               fail_count++;
               $display("%0t: expected key_code=%0d released=%0d, got key_code=%0d released=%0d",
                        $time, want.key_code, want.released, got.key_code, got.released);
            end
         end
      end
      // A long hold-off lets the block fill up and push back on the sender
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         long_hold_left = LONG_HOLD;
      end
      nxt_ready = 1'b1;
      if (reset) begin
         nxt_ready = 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left--;
         nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         nxt_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 3);
         nxt_ready = 1'b0;
      end
      rsp_tready <= nxt_ready;
   end

   // Watchdog: end the run if no word moves on any channel for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Write scan_set; the write also drops any partial sequence
   task automatic write_scan_set(input logic set_sel);
      csr_valid <= 1'b1;
      csr_data <= set_sel;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      cur_set = set_sel;
      seq_len = 3'd0;
      csr_valid <= 1'b0;
   endtask

   // Hold until every byte is taken and every key event has come, then let the pipe drain
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (scan_bytes.size() != 0 || req_tvalid || expected_keys.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random content, mostly in well-formed sequences of the active set, some raw noise
   task automatic queue_random_keystrokes(input logic set_sel, input int count);
      int         pick;
      int         pushed;
      logic [7:0] b;
      pushed = 0;
      while (pushed < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            do begin
               b = (set_sel == kbsa_pkg::SET_TWO && $urandom_range(0, 9) < 7) ?
                   8'($urandom_range(0, KEY_MAP_DEPTH - 1)) : 8'($urandom_range(0, 255));
            end while (b == BYTE_EXT || b == BYTE_PAUSE ||
                       (set_sel == kbsa_pkg::SET_TWO && b == BYTE_BREAK));
            scan_bytes.push_back(b);
            pushed += 1;
         end else if (pick < 62) begin
            // extended key; a random second byte may open a longer sequence
            b = 8'($urandom_range(0, 255));
            scan_bytes.push_back(BYTE_EXT);
            scan_bytes.push_back(b);
            pushed += 2;
         end else if (pick < 74) begin
            if (set_sel == kbsa_pkg::SET_ONE) begin
               scan_bytes.push_back(BYTE_EXT);
               scan_bytes.push_back($urandom_range(0, 1) ? PRTSC_MAKE : PRTSC_BREAK);
               scan_bytes.push_back(8'($urandom_range(0, 255)));
               scan_bytes.push_back(8'($urandom_range(0, 255)));
               pushed += 4;
            end else begin
               if ($urandom_range(0, 1)) begin
                  scan_bytes.push_back(BYTE_EXT);
                  pushed += 1;
               end
               scan_bytes.push_back(BYTE_BREAK);
               scan_bytes.push_back(8'($urandom_range(0, 255)));
               pushed += 2;
            end
         end else if (pick < 84) begin
            scan_bytes.push_back(BYTE_PAUSE);
            repeat ((set_sel == kbsa_pkg::SET_ONE) ? 5 : 7) begin
               scan_bytes.push_back(8'($urandom_range(0, 255)));
            end
            pushed += (set_sel == kbsa_pkg::SET_ONE) ? 6 : 8;
         end else begin
            repeat ($urandom_range(1, 3)) begin
               scan_bytes.push_back(8'($urandom_range(0, 255)));
               pushed += 1;
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Set 1: release threshold edges, extended keys, print screen with prefix bytes as data,
      // pause, and a lone extended prefix left open across the next register write
      write_scan_set(kbsa_pkg::SET_ONE);
      scan_bytes = '{8'h80, 8'hFF, 8'h00,
                     BYTE_EXT, 8'h1C,
                     BYTE_EXT, PRTSC_MAKE, BYTE_EXT, PRTSC_MAKE,
                     BYTE_EXT, PRTSC_BREAK, 8'hFF, 8'h00,
                     BYTE_PAUSE, BYTE_EXT, BYTE_BREAK, BYTE_PAUSE, 8'h55, 8'hAA,
                     BYTE_EXT};
      wait_idle();

      // Set 2: last table entry, first code past the table, break, extended break, pause,
      // and an open break prefix dropped by the next write
      write_scan_set(kbsa_pkg::SET_TWO);
      scan_bytes = '{8'h83, 8'h84,
                     BYTE_BREAK, 8'h1C,
                     BYTE_EXT, BYTE_BREAK, 8'h7C,
                     BYTE_PAUSE, 8'h14, 8'h77, BYTE_PAUSE, BYTE_BREAK, 8'h14, BYTE_BREAK, 8'h77,
                     BYTE_BREAK};
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         write_scan_set(phase[0] ? kbsa_pkg::SET_TWO : kbsa_pkg::SET_ONE);
         if (phase == 1) begin
            long_hold_req = 1'b1;
         end
         if (phase == 3) begin
            quiet = 1'b1;
         end
         queue_random_keystrokes(phase[0] ? kbsa_pkg::SET_TWO : kbsa_pkg::SET_ONE, PHASE_BYTES);
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
